### src/piaw_pkg.sv
// Shared types, widths and reset values for the PI regulator with anti-windup.
package piaw_pkg;

    // Default accumulator width (Q(ACC_WIDTH-16).16 integral)
    localparam int ACC_WIDTH_DEF = 40;

    // Field widths
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int PER_W      = 16;
    localparam int LIM_W      = 15;
    localparam int DRV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int FRAC_BITS = 24;              // fraction bits of the raw drive
    localparam int CHUNK_W   = 32;              // integral slice fed to the multiplier
    localparam int MUL_A_W   = CHUNK_W + 1;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int MUL_W     = MUL_A_W + MUL_B_W;
    localparam int PTERM_W   = 32;              // e * gain or e * period
    localparam int CAP_LOG   = 48;              // integral term magnitude cap 2^48
    localparam int CAP_W     = CAP_LOG + 2;
    localparam int RAW_W     = CAP_W + 2;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST    = 16'd0;
    localparam logic [PER_W-1:0]  SAMPLE_PERIOD_RST = 16'd655;
    localparam logic [LIM_W-1:0]  OUT_LIMIT_RST     = 15'd32767;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEG_GAIN    = 2'd1,
        CFG_SAMPLE_PERIOD = 2'd2,
        CFG_OUT_LIMIT     = 2'd3
    } t_cfg_reg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_PROP,
        ST_INTEG,
        ST_SUM,
        ST_FINAL
    } t_state;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_STEP,
        DP_PROP,
        DP_INTEG,
        DP_SUM,
        DP_FINAL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic last_chunk;
    } t_dp_status;

endpackage

### src/piaw_if.sv
// Channel interfaces: error sample input, drive output and register write.
interface piaw_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [piaw_pkg::ERR_W-1:0]   error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

interface piaw_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [piaw_pkg::DRV_W-1:0]   drive;
    logic                                saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

interface piaw_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [piaw_pkg::CFG_IDX_W-1:0]      index;
    logic [piaw_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/piaw_ctrl.sv
// Sequencer for the PI regulator: steps the shared-multiplier datapath per sample.
module piaw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  piaw_pkg::t_dp_status i_status,
    output piaw_pkg::t_dp_cmd    o_cmd
);

    piaw_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= piaw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op    = piaw_pkg::DP_NOP;
        unique case (r_state)
            piaw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = piaw_pkg::DP_LOAD;
                    n_state  = piaw_pkg::ST_STEP;
                end
            end
            piaw_pkg::ST_STEP: begin
                o_cmd.op = piaw_pkg::DP_STEP;
                n_state  = piaw_pkg::ST_PROP;
            end
            piaw_pkg::ST_PROP: begin
                o_cmd.op = piaw_pkg::DP_PROP;
                n_state  = piaw_pkg::ST_INTEG;
            end
            piaw_pkg::ST_INTEG: begin
                o_cmd.op = piaw_pkg::DP_INTEG;
                if (i_status.last_chunk) begin
                    n_state = piaw_pkg::ST_SUM;
                end
            end
            piaw_pkg::ST_SUM: begin
                o_cmd.op = piaw_pkg::DP_SUM;
                n_state  = piaw_pkg::ST_FINAL;
            end
            piaw_pkg::ST_FINAL: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = piaw_pkg::DP_FINAL;
                    n_out_valid = 1'b1;
                    n_state     = piaw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = piaw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == piaw_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == piaw_pkg::ST_STEP))
        else $error("transfer in did not start the sample sequence");

    a_valid_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == piaw_pkg::ST_FINAL))
        else $error("output valid rose outside the final step");

    a_final_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == piaw_pkg::ST_FINAL && r_out_valid && !i_out_ready)
        |=> (r_state == piaw_pkg::ST_FINAL))
        else $error("final step left while the output register was full");
`endif

endmodule

### src/piaw_datapath.sv
// Regulator datapath: config registers, shared multiplier, integral and clamp.
module piaw_datapath #(
    parameter int ACC_WIDTH = piaw_pkg::ACC_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  piaw_pkg::t_cfg_reg                  i_cfg_index,
    input  logic [piaw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [piaw_pkg::ERR_W-1:0]   i_error_sample,
    input  piaw_pkg::t_dp_cmd                   i_cmd,
    output piaw_pkg::t_dp_status                o_status,
    output logic signed [piaw_pkg::DRV_W-1:0]   o_drive,
    output logic                                o_saturated
);

    localparam int NCHUNK = (ACC_WIDTH + piaw_pkg::CHUNK_W - 1) / piaw_pkg::CHUNK_W;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W  = NCHUNK * piaw_pkg::CHUNK_W;
    localparam int TW     = ACC_WIDTH + piaw_pkg::GAIN_W + 1;
    localparam int EXT_W  = (TW > piaw_pkg::CAP_W) ? TW : piaw_pkg::CAP_W;
    localparam int SH_W   = CNT_W + $clog2(piaw_pkg::CHUNK_W);
    localparam int RAW_W  = piaw_pkg::RAW_W;
    localparam int DRV_W  = piaw_pkg::DRV_W;
    localparam int FB     = piaw_pkg::FRAC_BITS;

    localparam logic signed [EXT_W-1:0] CAP_P = EXT_W'(1) << piaw_pkg::CAP_LOG;
    localparam logic signed [EXT_W-1:0] CAP_N = -CAP_P;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [RAW_W-1:0] HALF_LSB = RAW_W'(1) << (FB - 1);
    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCHUNK - 1);

    // Configuration registers
    logic [piaw_pkg::GAIN_W-1:0] r_prop_gain, r_integ_gain;
    logic [piaw_pkg::PER_W-1:0]  r_sample_period;
    logic [piaw_pkg::LIM_W-1:0]  r_out_limit;

    // Working registers
    logic signed [piaw_pkg::ERR_W-1:0]   r_err;
    logic signed [piaw_pkg::MUL_W-1:0]   r_prod;
    logic signed [ACC_WIDTH-1:0]         r_acc, r_new_acc;
    logic signed [piaw_pkg::PTERM_W-1:0] r_pterm;
    logic signed [TW-1:0]                r_term;
    logic signed [RAW_W-1:0]             r_raw;
    logic [CNT_W-1:0]                    r_chunk;
    logic signed [DRV_W-1:0]             r_drive;
    logic                                r_sat;

    logic signed [piaw_pkg::MUL_A_W-1:0] mul_a;
    logic signed [piaw_pkg::MUL_B_W-1:0] mul_b;
    logic signed [piaw_pkg::MUL_W-1:0]   mul_p;
    logic signed [PAD_W-1:0]             acc_pad;
    logic [piaw_pkg::CHUNK_W-1:0]        chunk_bits;
    logic signed [TW-1:0]                part;
    logic signed [piaw_pkg::PTERM_W-1:0] step;
    logic signed [ACC_WIDTH:0]           acc_sum;
    logic signed [ACC_WIDTH-1:0]         acc_next;
    logic signed [EXT_W-1:0]             term_ext, term_cap;
    logic signed [RAW_W-1:0]             raw_sum, lim_pos, lim_neg, rounded;
    logic                                sat_pos, sat_neg, sat_now;
    logic signed [DRV_W-1:0]             drive_next;

    // Slice the new integral for the multiplier; top slice carries the sign
    assign acc_pad    = PAD_W'(r_new_acc);
    assign chunk_bits = acc_pad[{r_chunk, 5'b0} +: piaw_pkg::CHUNK_W];

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            piaw_pkg::DP_STEP: begin
                mul_a = piaw_pkg::MUL_A_W'(r_err);
                mul_b = $signed({1'b0, r_sample_period});
            end
            piaw_pkg::DP_PROP: begin
                mul_a = piaw_pkg::MUL_A_W'(r_err);
                mul_b = $signed({1'b0, r_prop_gain});
            end
            piaw_pkg::DP_INTEG: begin
                mul_a = (r_chunk == LAST_CHUNK)
                      ? $signed({chunk_bits[piaw_pkg::CHUNK_W-1], chunk_bits})
                      : $signed({1'b0, chunk_bits});
                mul_b = $signed({1'b0, r_integ_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign part  = TW'(mul_p) <<< SH_W'({r_chunk, 5'b0});

    // Saturating integral update
    assign step    = r_prod[piaw_pkg::PTERM_W-1:0];
    assign acc_sum = (ACC_WIDTH + 1)'(r_acc) + (ACC_WIDTH + 1)'(step);
    always_comb begin
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
            acc_next = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Cap the integral term and form the raw drive
    assign term_ext = EXT_W'(r_term);
    always_comb begin
        priority if (term_ext > CAP_P) begin
            term_cap = CAP_P;
        end else if (term_ext < CAP_N) begin
            term_cap = CAP_N;
        end else begin
            term_cap = term_ext;
        end
    end
    assign raw_sum = RAW_W'($signed(term_cap[piaw_pkg::CAP_W-1:0]))
                   + RAW_W'($signed({r_pterm, 16'h0000}));

    // Limit compare, clamp and round
    assign lim_pos = $signed(RAW_W'({r_out_limit, {FB{1'b0}}}));
    assign lim_neg = -lim_pos;
    assign sat_pos = (r_raw > lim_pos);
    assign sat_neg = (r_raw < lim_neg);
    assign sat_now = sat_pos | sat_neg;
    assign rounded = r_raw + HALF_LSB;
    always_comb begin
        priority if (sat_pos) begin
            drive_next = $signed({1'b0, r_out_limit});
        end else if (sat_neg) begin
            drive_next = -$signed({1'b0, r_out_limit});
        end else begin
            drive_next = rounded[FB +: DRV_W];
        end
    end

    // Configuration registers and integral state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= piaw_pkg::PROP_GAIN_RST;
            r_integ_gain    <= piaw_pkg::INTEG_GAIN_RST;
            r_sample_period <= piaw_pkg::SAMPLE_PERIOD_RST;
            r_out_limit     <= piaw_pkg::OUT_LIMIT_RST;
            r_acc           <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    piaw_pkg::CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                    piaw_pkg::CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data;
                    piaw_pkg::CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                    piaw_pkg::CFG_OUT_LIMIT:     r_out_limit     <= i_cfg_data[piaw_pkg::LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
            // keep the old integral when the drive saturates
            if (i_cmd.op == piaw_pkg::DP_FINAL && !sat_now) begin
                r_acc <= r_new_acc;
            end
        end
    end

    // Working registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            piaw_pkg::DP_LOAD: begin
                r_err <= i_error_sample;
            end
            piaw_pkg::DP_STEP: begin
                r_prod <= mul_p;
            end
            piaw_pkg::DP_PROP: begin
                r_new_acc <= acc_next;
                r_prod    <= mul_p;
                r_chunk   <= '0;
                r_term    <= '0;
            end
            piaw_pkg::DP_INTEG: begin
                r_term  <= r_term + part;
                r_chunk <= r_chunk + 1'b1;
                if (r_chunk == '0) begin
                    r_pterm <= r_prod[piaw_pkg::PTERM_W-1:0];
                end
            end
            piaw_pkg::DP_SUM: begin
                r_raw <= raw_sum;
            end
            piaw_pkg::DP_FINAL: begin
                r_drive <= drive_next;
                r_sat   <= sat_now;
            end
            default: begin
            end
        endcase
    end

    assign o_status.last_chunk = (r_chunk == LAST_CHUNK);
    assign o_drive             = r_drive;
    assign o_saturated         = r_sat;

`ifndef SYNTHESIS
    a_undo_on_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == piaw_pkg::DP_FINAL && sat_now) |=> $stable(r_acc))
        else $error("integral moved on a saturated sample");

    a_commit_on_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == piaw_pkg::DP_FINAL && !sat_now) |=> (r_acc == $past(r_new_acc)))
        else $error("integral not committed on an unsaturated sample");

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == piaw_pkg::DP_FINAL)
        |=> ($signed({r_drive[DRV_W-1], r_drive}) <= $signed({2'b00, $past(r_out_limit)})
             && $signed({r_drive[DRV_W-1], r_drive}) >= -$signed({2'b00, $past(r_out_limit)})))
        else $error("drive outside the output limit");
`endif

endmodule

### src/pi_regulator_anti_windup.sv
// Top level of the PI regulator with conditional-integration anti-windup.
//
//  channel  | modport     | payload                         | transfer
//  ---------+-------------+---------------------------------+-----------------------
//  i_in     | sink        | error_sample (s16)              | valid & ready
//  o_out    | source      | drive (s16), saturated          | valid & ready
//  i_cfg    | sink        | index (2), data (16)            | valid & ready (always)
//
//  A sample runs through the step, proportional, integral (ceil(ACC_WIDTH/32) slices),
//  sum and final states from transfer in to result valid; one 33x17 multiplier is
//  shared by the step, the proportional product and one 32-bit slice of the integral
//  per cycle.
//  A new sample is taken as soon as the sequencer is back in idle, while the previous
//  result may still sit in the output register; the final step waits on a full one.
//  Reset is synchronous, active low; it restores the registers and clears the integral.
module pi_regulator_anti_windup #(
    parameter int ACC_WIDTH = piaw_pkg::ACC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    piaw_in_if.sink    i_in,
    piaw_out_if.source o_out,
    piaw_cfg_if.sink   i_cfg
);

    piaw_pkg::t_dp_cmd    cmd;
    piaw_pkg::t_dp_status status;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    piaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    piaw_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (piaw_pkg::t_cfg_reg'(i_cfg.index)),
        .i_cfg_data     (i_cfg.data),
        .i_error_sample (i_in.error_sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_drive        (o_out.drive),
        .o_saturated    (o_out.saturated)
    );

endmodule
